>>> design/ilnf_pkg.sv
package ilnf_pkg;

    localparam int HEAP_BYTES_DEF  = 65536;
    localparam int CHUNK_BYTES_DEF = 4096;

    localparam int          LIMIT_W     = 17;
    localparam logic [16:0] LIMIT_RESET = 17'd65536;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_NOOP = 2'd1,
        ST_OOM  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] req_size;
        logic [15:0] ptr_in;
    } req_t;

    typedef struct packed {
        logic [15:0] ptr_out;
        status_t     status;
    } rsp_t;

endpackage

>>> design/ilnf_alu.sv
// Shared 32-bit adder/subtractor; bit 32 is the carry, or the borrow on a subtract.
module ilnf_alu (
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic        sub,
    output logic [32:0] y
);

    assign y = {1'b0, a} + ({33{sub}} ^ {1'b0, b}) + {32'd0, sub};

endmodule

>>> design/ilnf_mem.sv
module ilnf_mem #(
    parameter int AW = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/ilnf_seq.sv
module ilnf_seq #(
    parameter int HEAP_BYTES  = ilnf_pkg::HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = ilnf_pkg::CHUNK_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ilnf_pkg::req_t       start_item,
    input  logic [16:0]          heap_limit,
    input  logic                 out_free,
    output logic                 idle,
    output logic                 done,
    output ilnf_pkg::rsp_t       rsp
);

    localparam int NWORDS    = HEAP_BYTES / 4;
    localparam int AW        = $clog2(NWORDS);
    localparam int CS        = ((CHUNK_BYTES + 4) / 8) * 8;
    localparam int INIT_END  = 16 + CS;
    localparam int INIT_CAP  = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
    localparam bit INIT_GROW = (INIT_END <= INIT_CAP);
    localparam logic [16:0] BRK_INIT = INIT_GROW ? 17'(INIT_END) : 17'd16;
    localparam logic [2:0]  INIT_LAST = INIT_GROW ? 3'd5 : 3'd3;
    localparam logic [AW-1:0] INIT_FTR = AW'(INIT_END / 4 - 2);
    localparam logic [AW-1:0] INIT_EPI = AW'(INIT_END / 4 - 1);
    localparam logic [31:0] CS_TAG = 32'(CS);
    localparam logic [16:0] CS_17  = 17'(CS);

    typedef enum logic [32:0] {
        S_INIT  = 33'd1 << 0,
        S_IDLE  = 33'd1 << 1,
        S_FR1   = 33'd1 << 2,
        S_FR2   = 33'd1 << 3,
        S_M0    = 33'd1 << 4,
        S_M1    = 33'd1 << 5,
        S_M2    = 33'd1 << 6,
        S_M3    = 33'd1 << 7,
        S_M4    = 33'd1 << 8,
        S_M5    = 33'd1 << 9,
        S_MPA2  = 33'd1 << 10,
        S_MNA2  = 33'd1 << 11,
        S_MNA3  = 33'd1 << 12,
        S_MNN1  = 33'd1 << 13,
        S_MNN2  = 33'd1 << 14,
        S_MNN3  = 33'd1 << 15,
        S_MNN4  = 33'd1 << 16,
        S_MNN5  = 33'd1 << 17,
        S_MNN6  = 33'd1 << 18,
        S_MNN7  = 33'd1 << 19,
        S_MNN8  = 33'd1 << 20,
        S_MRET  = 33'd1 << 21,
        S_SRCH0 = 33'd1 << 22,
        S_SRCH1 = 33'd1 << 23,
        S_GROW0 = 33'd1 << 24,
        S_GROW1 = 33'd1 << 25,
        S_GROW2 = 33'd1 << 26,
        S_P0    = 33'd1 << 27,
        S_P1    = 33'd1 << 28,
        S_P2    = 33'd1 << 29,
        S_P3    = 33'd1 << 30,
        S_P4    = 33'd1 << 31,
        S_DONE  = 33'd1 << 32
    } state_t;

    state_t         state_reg, state_next;
    logic [2:0]     cnt_reg, cnt_next;
    logic [16:0]    brk_reg, brk_next;
    logic [31:0]    nfp_reg, nfp_next;
    ilnf_pkg::cmd_t cmd_reg, cmd_next;
    logic [16:0]    asize_reg, asize_next;
    logic [16:0]    size_reg, size_next;
    logic [31:0]    bp_reg, bp_next;
    logic [31:0]    nx_reg, nx_next;
    logic [31:0]    prv_reg, prv_next;
    logic [31:0]    tmp_reg, tmp_next;
    logic [31:0]    acc_reg, acc_next;
    logic [31:0]    sz0_reg, sz0_next;
    logic [31:0]    ph_reg, ph_next;
    logic [31:0]    nsz_reg, nsz_next;
    logic [31:0]    rsize_reg, rsize_next;
    logic [31:0]    hv_reg, hv_next;
    logic           split_reg, split_next;
    logic           pa_reg, pa_next;
    ilnf_pkg::rsp_t rsp_reg, rsp_next;

    logic [31:0]   alu_a, alu_b;
    logic          alu_sub;
    logic [32:0]   alu_y;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_q, qs;
    logic [16:0]   bound, grow_size;
    logic          split;

    function automatic logic [AW-1:0] widx(input logic [31:0] off, input logic [1:0] k);
        return off[AW+1:2] - AW'(k);
    endfunction

    ilnf_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y)
    );

    ilnf_mem #(.AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    assign qs = {mem_q[31:3], 3'b000};
    assign bound = ({15'd0, heap_limit} < 32'(HEAP_BYTES)) ? heap_limit : 17'(HEAP_BYTES);
    assign grow_size = (asize_reg > CS_17) ? asize_reg : CS_17;
    assign idle = (state_reg == S_IDLE);
    assign rsp = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        brk_next   = brk_reg;
        nfp_next   = nfp_reg;
        cmd_next   = cmd_reg;
        asize_next = asize_reg;
        size_next  = size_reg;
        bp_next    = bp_reg;
        nx_next    = nx_reg;
        prv_next   = prv_reg;
        tmp_next   = tmp_reg;
        acc_next   = acc_reg;
        sz0_next   = sz0_reg;
        ph_next    = ph_reg;
        nsz_next   = nsz_reg;
        rsize_next = rsize_reg;
        hv_next    = hv_reg;
        split_next = split_reg;
        pa_next    = pa_reg;
        rsp_next   = rsp_reg;
        alu_a      = bp_reg;
        alu_b      = 32'd0;
        alu_sub    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = 32'd0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        done       = 1'b0;
        split      = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                // Pad word, prologue, the first free chunk if it fits, then the epilogue.
                mem_we = 1'b1;
                case (cnt_reg)
                    3'd0:
                    begin
                        mem_waddr = AW'(0);
                        mem_wdata = 32'd0;
                    end
                    3'd1:
                    begin
                        mem_waddr = AW'(1);
                        mem_wdata = 32'd9;
                    end
                    3'd2:
                    begin
                        mem_waddr = AW'(2);
                        mem_wdata = 32'd9;
                    end
                    3'd3:
                    begin
                        mem_waddr = AW'(3);
                        mem_wdata = INIT_GROW ? CS_TAG : 32'd1;
                    end
                    3'd4:
                    begin
                        mem_waddr = INIT_FTR;
                        mem_wdata = CS_TAG;
                    end
                    default:
                    begin
                        mem_waddr = INIT_EPI;
                        mem_wdata = 32'd1;
                    end
                endcase
                if (cnt_reg == INIT_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = start_item.cmd;
                    if (start_item.cmd == ilnf_pkg::CMD_ALLOC)
                    begin
                        alu_a = {16'd0, start_item.req_size};
                        alu_b = 32'd15;
                        if (start_item.req_size == 16'd0)
                        begin
                            rsp_next   = '{ptr_out: 16'd0, status: ilnf_pkg::ST_NOOP};
                            state_next = S_DONE;
                        end
                        else
                        begin
                            asize_next = (start_item.req_size <= 16'd8) ? 17'd16
                                                                        : {alu_y[16:3], 3'b000};
                            state_next = S_SRCH0;
                        end
                    end
                    else if (start_item.ptr_in == 16'd0)
                    begin
                        rsp_next   = '{ptr_out: 16'd0, status: ilnf_pkg::ST_NOOP};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        bp_next    = {16'd0, start_item.ptr_in};
                        mem_re     = 1'b1;
                        mem_raddr  = widx({16'd0, start_item.ptr_in}, 2'd1);
                        state_next = S_FR1;
                    end
                end
            end

            S_FR1:
            begin
                sz0_next   = qs;
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg, 2'd1);
                mem_wdata  = qs;
                alu_b      = qs;
                tmp_next   = alu_y[31:0];
                state_next = S_FR2;
            end

            S_FR2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = widx(tmp_reg, 2'd2);
                mem_wdata  = sz0_reg;
                state_next = S_M0;
            end

            S_M0:
            begin
                mem_re     = 1'b1;
                mem_raddr  = widx(bp_reg, 2'd2);
                state_next = S_M1;
            end

            S_M1:
            begin
                alu_b      = qs;
                alu_sub    = 1'b1;
                prv_next   = alu_y[31:0];
                mem_re     = 1'b1;
                mem_raddr  = widx(alu_y[31:0], 2'd1);
                state_next = S_M2;
            end

            S_M2:
            begin
                ph_next    = qs;
                alu_a      = prv_reg;
                alu_b      = qs;
                mem_re     = 1'b1;
                mem_raddr  = widx(alu_y[31:0], 2'd2);
                state_next = S_M3;
            end

            S_M3:
            begin
                pa_next    = mem_q[0];
                mem_re     = 1'b1;
                mem_raddr  = widx(bp_reg, 2'd1);
                state_next = S_M4;
            end

            S_M4:
            begin
                sz0_next   = qs;
                alu_b      = qs;
                nx_next    = alu_y[31:0];
                mem_re     = 1'b1;
                mem_raddr  = widx(alu_y[31:0], 2'd1);
                state_next = S_M5;
            end

            S_M5:
            begin
                nsz_next = qs;
                alu_a    = sz0_reg;
                alu_b    = pa_reg ? qs : ph_reg;
                acc_next = alu_y[31:0];
                if (pa_reg && mem_q[0])
                begin
                    state_next = S_MRET;
                end
                else if (pa_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = widx(bp_reg, 2'd1);
                    mem_wdata  = alu_y[31:0];
                    state_next = S_MPA2;
                end
                else if (mem_q[0])
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = widx(nx_reg, 2'd2);
                    mem_wdata  = alu_y[31:0];
                    state_next = S_MNA2;
                end
                else
                begin
                    state_next = S_MNN1;
                end
            end

            S_MPA2:
            begin
                alu_b      = acc_reg;
                mem_we     = 1'b1;
                mem_waddr  = widx(alu_y[31:0], 2'd2);
                mem_wdata  = acc_reg;
                state_next = S_MRET;
            end

            S_MNA2:
            begin
                // The footer write may have hit the word below the block; look again.
                mem_re     = 1'b1;
                mem_raddr  = widx(bp_reg, 2'd2);
                state_next = S_MNA3;
            end

            S_MNA3:
            begin
                alu_b      = qs;
                alu_sub    = 1'b1;
                bp_next    = alu_y[31:0];
                mem_we     = 1'b1;
                mem_waddr  = widx(alu_y[31:0], 2'd1);
                mem_wdata  = acc_reg;
                state_next = S_MRET;
            end

            S_MNN1:
            begin
                alu_a      = nx_reg;
                alu_b      = nsz_reg;
                mem_re     = 1'b1;
                mem_raddr  = widx(alu_y[31:0], 2'd2);
                state_next = S_MNN2;
            end

            S_MNN2:
            begin
                alu_a      = acc_reg;
                alu_b      = qs;
                acc_next   = alu_y[31:0];
                state_next = S_MNN3;
            end

            S_MNN3:
            begin
                mem_we     = 1'b1;
                mem_waddr  = widx(prv_reg, 2'd1);
                mem_wdata  = acc_reg;
                state_next = S_MNN4;
            end

            S_MNN4:
            begin
                // Walk the tags again, since the new header may alias them.
                mem_re     = 1'b1;
                mem_raddr  = widx(bp_reg, 2'd1);
                state_next = S_MNN5;
            end

            S_MNN5:
            begin
                alu_b      = qs;
                nx_next    = alu_y[31:0];
                mem_re     = 1'b1;
                mem_raddr  = widx(alu_y[31:0], 2'd1);
                state_next = S_MNN6;
            end

            S_MNN6:
            begin
                alu_a      = nx_reg;
                alu_b      = qs;
                mem_we     = 1'b1;
                mem_waddr  = widx(alu_y[31:0], 2'd2);
                mem_wdata  = acc_reg;
                state_next = S_MNN7;
            end

            S_MNN7:
            begin
                mem_re     = 1'b1;
                mem_raddr  = widx(bp_reg, 2'd2);
                state_next = S_MNN8;
            end

            S_MNN8:
            begin
                alu_b      = qs;
                alu_sub    = 1'b1;
                bp_next    = alu_y[31:0];
                state_next = S_MRET;
            end

            S_MRET:
            begin
                if (cmd_reg == ilnf_pkg::CMD_FREE)
                begin
                    nfp_next   = bp_reg;
                    rsp_next   = '{ptr_out: 16'd0, status: ilnf_pkg::ST_DONE};
                    state_next = S_DONE;
                end
                else if (bp_reg == 32'd0)
                begin
                    rsp_next   = '{ptr_out: 16'd0, status: ilnf_pkg::ST_OOM};
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_P0;
                end
            end

            S_SRCH0:
            begin
                bp_next = nfp_reg;
                alu_a   = {15'd0, brk_reg};
                alu_b   = nfp_reg;
                alu_sub = 1'b1;
                if ((nfp_reg < 32'd8) || alu_y[32])
                begin
                    state_next = S_GROW0;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = widx(nfp_reg, 2'd1);
                    state_next = S_SRCH1;
                end
            end

            S_SRCH1:
            begin
                // One header per cycle until a fit, a zero size or the break.
                alu_b = qs;
                if (qs == 32'd0)
                begin
                    state_next = S_GROW0;
                end
                else if (!mem_q[0] && ({15'd0, asize_reg} <= qs))
                begin
                    nfp_next   = bp_reg;
                    state_next = S_P0;
                end
                else if (alu_y > {16'd0, brk_reg})
                begin
                    state_next = S_GROW0;
                end
                else
                begin
                    bp_next   = alu_y[31:0];
                    mem_re    = 1'b1;
                    mem_raddr = widx(alu_y[31:0], 2'd1);
                end
            end

            S_GROW0:
            begin
                alu_a = {15'd0, brk_reg};
                alu_b = {15'd0, grow_size};
                if (alu_y > {16'd0, bound})
                begin
                    rsp_next   = '{ptr_out: 16'd0, status: ilnf_pkg::ST_OOM};
                    state_next = S_DONE;
                end
                else
                begin
                    bp_next    = {15'd0, brk_reg};
                    brk_next   = alu_y[16:0];
                    tmp_next   = alu_y[31:0];
                    size_next  = grow_size;
                    mem_we     = 1'b1;
                    mem_waddr  = widx({15'd0, brk_reg}, 2'd1);
                    mem_wdata  = {15'd0, grow_size};
                    state_next = S_GROW1;
                end
            end

            S_GROW1:
            begin
                mem_we     = 1'b1;
                mem_waddr  = widx(tmp_reg, 2'd2);
                mem_wdata  = {15'd0, size_reg};
                state_next = S_GROW2;
            end

            S_GROW2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = widx(tmp_reg, 2'd1);
                mem_wdata  = 32'd1;
                state_next = S_M0;
            end

            S_P0:
            begin
                mem_re     = 1'b1;
                mem_raddr  = widx(bp_reg, 2'd1);
                state_next = S_P1;
            end

            S_P1:
            begin
                rsize_next = qs;
                alu_a      = qs;
                alu_b      = {15'd0, asize_reg};
                alu_sub    = 1'b1;
                split      = !alu_y[32] && (alu_y[31:0] >= 32'd16);
                split_next = split;
                hv_next    = split ? {15'd0, asize_reg} : qs;
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg, 2'd1);
                mem_wdata  = (split ? {15'd0, asize_reg} : qs) | 32'd1;
                state_next = S_P2;
            end

            S_P2:
            begin
                alu_b     = hv_reg;
                tmp_next  = alu_y[31:0];
                mem_we    = 1'b1;
                mem_waddr = widx(alu_y[31:0], 2'd2);
                mem_wdata = hv_reg | 32'd1;
                if (split_reg)
                begin
                    state_next = S_P3;
                end
                else
                begin
                    rsp_next   = '{ptr_out: bp_reg[15:0], status: ilnf_pkg::ST_DONE};
                    state_next = S_DONE;
                end
            end

            S_P3:
            begin
                alu_a      = rsize_reg;
                alu_b      = {15'd0, asize_reg};
                alu_sub    = 1'b1;
                acc_next   = alu_y[31:0];
                mem_we     = 1'b1;
                mem_waddr  = widx(tmp_reg, 2'd1);
                mem_wdata  = alu_y[31:0];
                state_next = S_P4;
            end

            S_P4:
            begin
                alu_a      = tmp_reg;
                alu_b      = acc_reg;
                mem_we     = 1'b1;
                mem_waddr  = widx(alu_y[31:0], 2'd2);
                mem_wdata  = acc_reg;
                rsp_next   = '{ptr_out: bp_reg[15:0], status: ilnf_pkg::ST_DONE};
                state_next = S_DONE;
            end

            S_DONE:
            begin
                done = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= 3'd0;
            brk_reg   <= BRK_INIT;
            nfp_reg   <= 32'd8;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            brk_reg   <= brk_next;
            nfp_reg   <= nfp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        asize_reg <= asize_next;
        size_reg  <= size_next;
        bp_reg    <= bp_next;
        nx_reg    <= nx_next;
        prv_reg   <= prv_next;
        tmp_reg   <= tmp_next;
        acc_reg   <= acc_next;
        sz0_reg   <= sz0_next;
        ph_reg    <= ph_next;
        nsz_reg   <= nsz_next;
        rsize_reg <= rsize_next;
        hv_reg    <= hv_next;
        split_reg <= split_next;
        pa_reg    <= pa_next;
        rsp_reg   <= rsp_next;
    end

`ifndef SYNTH
    a_brk_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> brk_reg >= $past(brk_reg))
        else $error("heap break moved down");

    a_brk_cap: assert property (@(posedge clk) disable iff (!rst_n)
        {15'd0, brk_reg} <= 32'(HEAP_BYTES))
        else $error("heap break beyond heap memory");

    a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("tag read and write in the same cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> state_reg != S_IDLE)
        else $error("accepted beat did not start the sequencer");
`endif

endmodule

>>> design/implicit_list_next_fit_allocator_core.sv
// Heap allocator over an internal tag memory (implicit block list, next-fit
// search). After reset the block lays down the initial heap and stalls
// requests until then. One request is worked at a time through a single
// 32-bit adder and one registered memory read port. A zero-size allocate or a
// null free goes straight to the result; a free merges the block with its
// free neighbours. An allocate visits block headers from the next-fit pointer,
// extends the heap when no free block fits, then places the block. The result
// sits in an output register, so a new request is taken while it waits.
// HEAP_BYTES must be a power of two.
module implicit_list_next_fit_allocator_core #(
    parameter int HEAP_BYTES  = ilnf_pkg::HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = ilnf_pkg::CHUNK_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ilnf_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ilnf_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [16:0]    cfg_data
);

    logic           seq_idle, seq_done, out_free, start;
    ilnf_pkg::rsp_t seq_rsp, rsp_reg;
    logic           rsp_valid_reg;
    logic [16:0]    heap_limit_reg;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign start     = req_valid && seq_idle;
    assign req_stall = !seq_idle;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    ilnf_seq #(
        .HEAP_BYTES  (HEAP_BYTES),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_item (req),
        .heap_limit (heap_limit_reg),
        .out_free   (out_free),
        .idle       (seq_idle),
        .done       (seq_done),
        .rsp        (seq_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            heap_limit_reg <= ilnf_pkg::LIMIT_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                heap_limit_reg <= cfg_data;
            end
            if (out_free)
            begin
                rsp_valid_reg <= seq_done;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && seq_done)
        begin
            rsp_reg <= seq_rsp;
        end
    end

endmodule

>>> tb/sv/implicit_list_next_fit_allocator_checker.sv
module implicit_list_next_fit_allocator_checker
    import ilnf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_t        req,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_t        rsp,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [16:0] cfg_data,
    output int          errors,
    output int          pending
);

    localparam int HEAP_WORDS = HEAP_BYTES_DEF / 4;

    logic [31:0] heap_mem [HEAP_WORDS];
    logic [31:0] brk;
    logic [31:0] rover;
    logic [16:0] limit;
    rsp_t        rsp_q[$];

    function automatic logic [31:0] tag_rd(logic [31:0] off);
        return heap_mem[off[15:2]];
    endfunction

    function automatic void tag_wr(logic [31:0] off, logic [31:0] v);
        heap_mem[off[15:2]] = v;
    endfunction

    function automatic logic [31:0] blk_size(logic [31:0] off);
        return tag_rd(off) & ~32'd7;
    endfunction

    function automatic logic blk_used(logic [31:0] off);
        logic [31:0] t;
        t = tag_rd(off);
        return t[0];
    endfunction

    function automatic logic [31:0] foot_of(logic [31:0] bp);
        return bp + blk_size(bp - 32'd4) - 32'd8;
    endfunction

    function automatic logic [31:0] next_of(logic [31:0] bp);
        return bp + blk_size(bp - 32'd4);
    endfunction

    function automatic logic [31:0] prev_of(logic [31:0] bp);
        return bp - blk_size(bp - 32'd8);
    endfunction

    function automatic logic [31:0] coalesce(logic [31:0] bp);
        logic        pu;
        logic        nu;
        logic [31:0] sz;
        pu = blk_used(foot_of(prev_of(bp)));
        nu = blk_used(next_of(bp) - 32'd4);
        sz = blk_size(bp - 32'd4);
        if (pu && nu)
            return bp;
        if (pu)
        begin
            sz += blk_size(next_of(bp) - 32'd4);
            tag_wr(bp - 32'd4, sz);
            tag_wr(foot_of(bp), sz);
            return bp;
        end
        if (nu)
        begin
            sz += blk_size(prev_of(bp) - 32'd4);
            tag_wr(foot_of(bp), sz);
            tag_wr(prev_of(bp) - 32'd4, sz);
            return prev_of(bp);
        end
        sz += blk_size(prev_of(bp) - 32'd4) + blk_size(foot_of(next_of(bp)));
        tag_wr(prev_of(bp) - 32'd4, sz);
        tag_wr(foot_of(next_of(bp)), sz);
        return prev_of(bp);
    endfunction

    function automatic void place(logic [31:0] bp, logic [31:0] asize);
        logic [31:0] rsize;
        rsize = blk_size(bp - 32'd4);
        if (rsize >= asize && rsize - asize >= 32'd16)
        begin
            tag_wr(bp - 32'd4, asize | 32'd1);
            tag_wr(foot_of(bp), asize | 32'd1);
            bp = next_of(bp);
            tag_wr(bp - 32'd4, rsize - asize);
            tag_wr(foot_of(bp), rsize - asize);
        end
        else
        begin
            tag_wr(bp - 32'd4, rsize | 32'd1);
            tag_wr(foot_of(bp), rsize | 32'd1);
        end
    endfunction

    function automatic logic [31:0] grow_heap(logic [31:0] bytes);
        logic [63:0] words;
        logic [63:0] grow_by;
        logic [63:0] bound;
        logic [31:0] bp;
        words = 64'(bytes) / 64'd4;
        if (words[0])
            words++;
        grow_by = words * 64'd4;
        bound = (32'(limit) < HEAP_BYTES_DEF) ? 64'(limit) : 64'(HEAP_BYTES_DEF);
        if (64'(brk) + grow_by > bound)
            return 32'd0;
        bp = brk;
        brk = brk + grow_by[31:0];
        tag_wr(bp - 32'd4, grow_by[31:0]);
        tag_wr(foot_of(bp), grow_by[31:0]);
        tag_wr(next_of(bp) - 32'd4, 32'd1);
        return coalesce(bp);
    endfunction

    function automatic logic [31:0] next_fit(logic [31:0] asize);
        logic [31:0] bp;
        logic [31:0] sz;
        logic [63:0] nb;
        bp = rover;
        if (bp < 32'd8 || bp > brk)
            return 32'd0;
        forever
        begin
            sz = blk_size(bp - 32'd4);
            if (sz == 32'd0)
                return 32'd0;
            if (!blk_used(bp - 32'd4) && asize <= sz)
            begin
                rover = bp;
                return bp;
            end
            nb = 64'(bp) + 64'(sz);
            if (nb > 64'(brk))
                return 32'd0;
            bp = nb[31:0];
        end
    endfunction

    function automatic rsp_t serve(req_t r);
        rsp_t        o;
        logic [31:0] asize;
        logic [31:0] bp;
        logic [31:0] sz;
        o.ptr_out = '0;
        o.status  = ST_DONE;
        if (r.cmd == CMD_ALLOC)
        begin
            if (r.req_size == 16'd0)
                o.status = ST_NOOP;
            else
            begin
                asize = (r.req_size <= 16'd8) ? 32'd16
                                              : 32'd8 * ((32'(r.req_size) + 32'd15) / 32'd8);
                bp = next_fit(asize);
                if (bp == 32'd0)
                    bp = grow_heap((asize > 32'(CHUNK_BYTES_DEF)) ? asize
                                                                  : 32'(CHUNK_BYTES_DEF));
                if (bp == 32'd0)
                    o.status = ST_OOM;
                else
                begin
                    place(bp, asize);
                    o.ptr_out = bp[15:0];
                end
            end
        end
        else if (r.ptr_in == 16'd0)
            o.status = ST_NOOP;
        else
        begin
            sz = blk_size(32'(r.ptr_in) - 32'd4);
            tag_wr(32'(r.ptr_in) - 32'd4, sz);
            tag_wr(foot_of(32'(r.ptr_in)), sz);
            rover = coalesce(32'(r.ptr_in));
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < HEAP_WORDS; i++)
                heap_mem[i] = '0;
            limit = LIMIT_RESET;
            tag_wr(32'd4, 32'd9);
            tag_wr(32'd8, 32'd9);
            tag_wr(32'd12, 32'd1);
            brk   = 32'd16;
            rover = 32'd8;
            void'(grow_heap(32'(CHUNK_BYTES_DEF)));
            rsp_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit = cfg_data;
            if (req_valid && !req_stall)
                rsp_q.push_back(serve(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response beat ptr %h status %0d",
                             $time, rsp.ptr_out, rsp.status);
                end
                else
                begin
                    want = rsp_q.pop_front();
                    if (rsp.ptr_out !== want.ptr_out || rsp.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: mismatch expected ptr %h status %0d, got ptr %h status %0d",
                                 $time, want.ptr_out, want.status, rsp.ptr_out, rsp.status);
                    end
                end
            end
            pending = rsp_q.size();
        end
    end

endmodule

>>> tb/sv/implicit_list_next_fit_allocator_core_tb.sv
module implicit_list_next_fit_allocator_core_tb;
    import ilnf_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          cycles = 0;
    int          sent = 0;
    logic [15:0] live_ptrs[$];

    implicit_list_next_fit_allocator_core dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    implicit_list_next_fit_allocator_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        rsp_stall <= ($urandom_range(99) < stall_pct);
        // Only pointers that have come back may be freed later.
        if (rsp_valid && !rsp_stall && rsp.status == ST_DONE && rsp.ptr_out != 0)
            live_ptrs.push_back(rsp.ptr_out);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(req_t item);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        sent++;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
    endtask

    task automatic alloc(logic [15:0] size);
        req_t item;
        item.cmd      = CMD_ALLOC;
        item.req_size = size;
        item.ptr_in   = 16'($urandom());
        send(item);
    endtask

    task automatic release_ptr(logic [15:0] p);
        req_t item;
        item.cmd      = CMD_FREE;
        item.req_size = 16'($urandom());
        item.ptr_in   = p;
        send(item);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_limit(logic [16:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_traffic(int n, int idle, int stall);
        int r;
        int k;
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 3)
                alloc(16'd0);
            else if (r < 6)
                release_ptr(16'd0);
            else if (r < 50 && live_ptrs.size() != 0)
            begin
                k = $urandom_range(live_ptrs.size() - 1);
                release_ptr(live_ptrs[k]);
                live_ptrs.delete(k);
            end
            else if (r < 80)
                alloc(16'($urandom_range(64, 1)));
            else if (r < 92)
                alloc(16'($urandom_range(1024, 65)));
            else if (r < 97)
                alloc(16'($urandom_range(20000, 1025)));
            else
                alloc(16'($urandom()));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_limit(17'd65536);

        alloc(16'd0);
        release_ptr(16'd0);
        alloc(16'd1);
        alloc(16'd8);
        alloc(16'd9);
        alloc(16'd16);
        alloc(16'd4000);
        alloc(16'd65535);
        alloc(16'd40000);
        alloc(16'd24);
        // Hold off until every pointer is back, then free around a neighbor
        // so that both-sided merges happen.
        drain();
        if (live_ptrs.size() >= 3)
        begin
            release_ptr(live_ptrs[0]);
            release_ptr(live_ptrs[2]);
            release_ptr(live_ptrs[1]);
            live_ptrs = live_ptrs[3:$];
        end
        alloc(16'd20);
        alloc(16'd65528);

        random_traffic(150, 0, 0);
        random_traffic(150, 57, 0);
        set_limit(17'd8192);
        random_traffic(75, 0, 57);
        set_limit(17'd16);
        random_traffic(50, 35, 35);
        set_limit(17'd131071);
        random_traffic(175, 35, 35);

        drain();
        repeat (50) @(posedge clk);
        $display("Sent %0d requests (allocate, free, no-op, out of memory) over", sent);
        $display("heap limits 65536, 8192, 16 and 131071 with random idle and stall.");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
